// File: hw/rtl/rotating_beacon_column_renderer_unit_assert.svh
// Assertion helpers used by the renderer top module.
`ifndef ROTATING_BEACON_COLUMN_RENDERER_UNIT_ASSERT_SVH
`define ROTATING_BEACON_COLUMN_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RBCR_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RBCR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/rbcr_pkg.sv
package rbcr_pkg;

  // Grid geometry: one store entry per column, x in the high index bits.
  localparam int GRID_SIDE  = 8;
  localparam int COORD_W    = 3;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int COLS       = GRID_SIDE * GRID_SIDE;
  localparam int CNT_W      = ADDR_W + 1;

  // Levels and timing.
  localparam logic [7:0]  MIN_LEVEL   = 8'd96;
  localparam logic [7:0]  FULL_LEVEL  = 8'd255;
  localparam logic [7:0]  LEVEL_SPAN  = 8'd159;
  localparam logic [31:0] BASE_PERIOD = 32'd20;
  localparam logic [9:0]  BIAS_RESET  = 10'd512;

  // Configuration register indexes.
  localparam logic [2:0] REG_BICOLOR     = 3'd0;
  localparam logic [2:0] REG_AUDIO       = 3'd1;
  localparam logic [2:0] REG_TRAIL       = 3'd2;
  localparam logic [2:0] REG_FRAME_DELAY = 3'd3;
  localparam logic [2:0] REG_ADC_BIAS    = 3'd4;

  // Request bundle from the sequencer to the column store.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic              frame_done;
  } mem_req_t;

  // Beam direction, x component.
  function automatic logic signed [1:0] dir_x(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd0, 3'd1, 3'd7: v = 2'sd1;
      3'd2, 3'd6:       v = 2'sd0;
      default:          v = -2'sd1;
    endcase
    return v;
  endfunction

  // Beam direction, z component.
  function automatic logic signed [1:0] dir_z(input logic [2:0] d);
    logic signed [1:0] v;
    case (d)
      3'd1, 3'd2, 3'd3: v = 2'sd1;
      3'd0, 3'd4:       v = 2'sd0;
      default:          v = -2'sd1;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/rbcr_level.sv
module rbcr_level (
  input  logic       clk,
  input  logic       rst,
  input  logic       update,
  input  logic       audio_react,
  input  logic [9:0] adc_bias,
  input  logic [9:0] sample_a,
  input  logic [9:0] sample_b,
  input  logic [9:0] sample_c,
  input  logic [9:0] sample_d,
  output logic [7:0] level
);

  logic [9:0]  envelope;
  logic [9:0]  dev_a, dev_b, dev_c, dev_d;
  logic [9:0]  peak_ab, peak_cd, peak;
  logic [12:0] env_x7;
  logic [9:0]  decayed;
  logic [9:0]  envelope_next;
  logic [7:0]  add_raw, add_cap;

  function automatic logic [9:0] abs_dev(input logic [9:0] s, input logic [9:0] b);
    return (s >= b) ? (s - b) : (b - s);
  endfunction

  // Peak deviation from the bias and the 7/8 decay of the held envelope.
  always_comb begin
    dev_a         = abs_dev(sample_a, adc_bias);
    dev_b         = abs_dev(sample_b, adc_bias);
    dev_c         = abs_dev(sample_c, adc_bias);
    dev_d         = abs_dev(sample_d, adc_bias);
    peak_ab       = (dev_a >= dev_b) ? dev_a : dev_b;
    peak_cd       = (dev_c >= dev_d) ? dev_c : dev_d;
    peak          = (peak_ab >= peak_cd) ? peak_ab : peak_cd;
    env_x7        = {3'b000, envelope} * 13'd7;
    decayed       = env_x7[12:3];
    envelope_next = (peak > decayed) ? peak : decayed;
    add_raw       = envelope_next[9:2];
    add_cap       = (add_raw > rbcr_pkg::LEVEL_SPAN) ? rbcr_pkg::LEVEL_SPAN : add_raw;
  end

  // The envelope only moves when audio follows; the level is set once per frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (update && audio_react) begin
      envelope <= envelope_next;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      level <= audio_react ? (rbcr_pkg::MIN_LEVEL + add_cap) : rbcr_pkg::FULL_LEVEL;
    end
  end

endmodule

// File: hw/rtl/rbcr_column_store.sv
module rbcr_column_store (
  input  logic               clk,
  input  logic               rst,
  input  rbcr_pkg::mem_req_t req,
  output logic [15:0]        rdata
);

  logic [15:0] mem [rbcr_pkg::COLS];
  logic [15:0] q;
  logic        filled;

  // Single-port-per-direction memory, registered read.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      q <= mem[req.raddr];
    end
  end

  // Every frame rewrites all columns in order, so until the first frame has
  // finished, any read sees a column that was never written: it reads black.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= 1'b0;
    end else if (req.frame_done) begin
      filled <= 1'b1;
    end
  end

  assign rdata = filled ? q : 16'h0000;

endmodule

// File: hw/rtl/rotating_beacon_column_renderer_unit.sv
// Rotating beacon renderer. Each input beat is a tick: time_ms and four
// microphone samples. A tick before the deadline (time_ms - next deadline has
// bit 31 set) produces nothing; the sequencer goes from decide back to idle. A
// due tick produces 64 output beats, one per column, x outer and z inner, tlast
// on the final one. The 64-entry column store is read, faded, painted and
// written back one column per cycle while the output accepts, through its
// single read and single write port. A new tick is taken only after the
// previous frame has been swept; the last output beat may still wait in the
// output register. No clearing pass after reset: the store reads black until
// the first frame has been written. Configuration writes take effect at once
// and are meant for idle periods.
`include "rotating_beacon_column_renderer_unit_assert.svh"

module rotating_beacon_column_renderer_unit (
  input  logic        clk,
  input  logic        rst,
  // Tick input.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,    // time_ms[31:0], mic_sample_a, _b, _c, _d (10 bits each)
  // Column output.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // column_x[2:0], column_z[5:3], red_level[13:6],
                                  // blue_level[21:14], zero fill
  output logic        m_tlast,    // frame_end
  // Configuration.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN
  } state_t;

  state_t state;

  // Configuration registers.
  logic        bicolor_mode;
  logic        audio_react;
  logic        trail_mode;
  logic [15:0] frame_delay;
  logic [9:0]  adc_bias;

  // Frame state.
  logic [2:0]  direction_index;
  logic [31:0] next_frame_time;
  logic [31:0] time_q;
  logic [9:0]  sample_a, sample_b, sample_c, sample_d;

  // Sweep control.
  logic [rbcr_pkg::CNT_W-1:0]  issue_cnt;
  logic                        rd_pending;
  logic [rbcr_pkg::ADDR_W-1:0] rd_addr;

  logic               due;
  logic               level_update;
  logic [7:0]         level;
  logic               advance;
  logic               issue;
  logic               last_col;
  rbcr_pkg::mem_req_t store_req;
  logic [15:0]        store_rdata;

  // Shading signals.
  logic [2:0]        col_x, col_z;
  logic signed [5:0] cx, cz, dx, dz, cross_term, along;
  logic [5:0]        cross_abs;
  logic              diag, lit;
  logic [7:0]        lv;
  logic [15:0]       faded, shaded;

  // Configuration write port.
  always_ff @(posedge clk) begin
    if (rst) begin
      bicolor_mode <= 1'b0;
      audio_react  <= 1'b0;
      trail_mode   <= 1'b0;
      frame_delay  <= '0;
      adc_bias     <= rbcr_pkg::BIAS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        rbcr_pkg::REG_BICOLOR:     bicolor_mode <= cfg_wdata[0];
        rbcr_pkg::REG_AUDIO:       audio_react  <= cfg_wdata[0];
        rbcr_pkg::REG_TRAIL:       trail_mode   <= cfg_wdata[0];
        rbcr_pkg::REG_FRAME_DELAY: frame_delay  <= cfg_wdata;
        rbcr_pkg::REG_ADC_BIAS:    adc_bias     <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Handshake and sweep decisions.
  assign s_tready     = (state == ST_IDLE);
  assign due          = ~(time_q - next_frame_time) >> 31 == 32'd1;
  assign level_update = (state == ST_DECIDE) && due;
  assign advance      = rd_pending && (!m_tvalid || m_tready);
  assign issue        = (state == ST_SCAN) && !issue_cnt[rbcr_pkg::CNT_W-1]
                        && (!rd_pending || advance);
  assign last_col     = (rd_addr == rbcr_pkg::ADDR_W'(rbcr_pkg::COLS - 1));

  rbcr_level u_level (
    .clk         (clk),
    .rst         (rst),
    .update      (level_update),
    .audio_react (audio_react),
    .adc_bias    (adc_bias),
    .sample_a    (sample_a),
    .sample_b    (sample_b),
    .sample_c    (sample_c),
    .sample_d    (sample_d),
    .level       (level)
  );

  // Column geometry from the address whose stored value has just come back.
  always_comb begin
    col_x      = rd_addr[rbcr_pkg::ADDR_W-1:rbcr_pkg::COORD_W];
    col_z      = rd_addr[rbcr_pkg::COORD_W-1:0];
    cx         = $signed({2'b00, col_x, 1'b0}) - 6'sd7;
    cz         = $signed({2'b00, col_z, 1'b0}) - 6'sd7;
    dx         = 6'(rbcr_pkg::dir_x(direction_index));
    dz         = 6'(rbcr_pkg::dir_z(direction_index));
    cross_term = cx * dz - cz * dx;
    along      = cx * dx + cz * dz;
    cross_abs  = cross_term[5] ? 6'(-cross_term) : cross_term;
    diag       = (dx != 6'sd0) && (dz != 6'sd0);
    lit        = cross_abs <= (diag ? 6'd2 : 6'd1);
    lv         = (diag && cross_abs != 6'd0) ? {1'b0, level[7:1]} : level;
    faded      = trail_mode ? {1'b0, store_rdata[15:9], 1'b0, store_rdata[7:1]} : 16'h0000;
    if (!lit) begin
      shaded = faded;
    end else if (bicolor_mode && along[5]) begin
      shaded = {lv, 8'h00};
    end else begin
      shaded = {8'h00, lv};
    end
  end

  // Store requests: read ahead, write back the shaded column on advance.
  always_comb begin
    store_req.re         = issue;
    store_req.raddr      = issue_cnt[rbcr_pkg::ADDR_W-1:0];
    store_req.we         = advance;
    store_req.waddr      = rd_addr;
    store_req.wdata      = shaded;
    store_req.frame_done = advance && last_col;
  end

  rbcr_column_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (store_req),
    .rdata (store_rdata)
  );

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      direction_index <= '0;
      next_frame_time <= '0;
      issue_cnt       <= '0;
      rd_pending      <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          issue_cnt <= '0;
          state     <= due ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          if (advance && last_col) begin
            state           <= ST_IDLE;
            direction_index <= direction_index + 3'd1;
            next_frame_time <= time_q + rbcr_pkg::BASE_PERIOD + {16'h0000, frame_delay};
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (issue) begin
        issue_cnt  <= issue_cnt + rbcr_pkg::CNT_W'(1);
        rd_pending <= 1'b1;
      end else if (advance) begin
        rd_pending <= 1'b0;
      end

      if (advance) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {2'b00, shaded[7:0], shaded[15:8], col_z, col_x};
        m_tlast  <= last_col;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      time_q   <= s_tdata[31:0];
      sample_a <= s_tdata[41:32];
      sample_b <= s_tdata[51:42];
      sample_c <= s_tdata[61:52];
      sample_d <= s_tdata[71:62];
    end
    if (issue) begin
      rd_addr <= issue_cnt[rbcr_pkg::ADDR_W-1:0];
    end
  end

  `RBCR_ASSERT_IMPLY(a_idle_no_read, clk, rst, s_tready, !rd_pending, "read pending while idle")
  `RBCR_ASSERT_IMPLY(a_write_in_scan, clk, rst, store_req.we, state == ST_SCAN, "write off sweep")
  `RBCR_ASSERT_IMPLY(a_last_is_corner, clk, rst, m_tvalid && m_tlast, m_tdata[5:0] == 6'h3F, "bad end")
  `RBCR_ASSERT_NEXT(a_late_tick_drops, clk, rst, state == ST_DECIDE && !due, state == ST_IDLE, "late tick")

endmodule
